[hdl/dpb_pkg.sv]
// ----------------------------------------------------------------------------
// dpb_pkg
// Types, constants and helpers shared by the depth back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 40;
  localparam int DMAG_W    = 32;
  localparam int PROD_W    = 48;
  localparam int T_W       = 80;
  localparam int ACC_W     = 112;
  localparam int QUO_W     = 64;
  localparam int GAIN_FRAC = 24;

  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'((64'd1 << (OUT_W-1)) - 64'd1);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(64'd1 << (OUT_W-1));

  typedef enum logic [2:0] {
    REG_DEPTH_GAIN     = 3'd0,
    REG_CENTER_U       = 3'd1,
    REG_CENTER_V       = 3'd2,
    REG_INV_FOCAL_U    = 3'd3,
    REG_INV_FOCAL_V    = 3'd4,
    REG_FOCAL_BASELINE = 3'd5,
    REG_DISPARITY_MAX  = 3'd6,
    REG_UVD_MODE       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] depth_gain;
    logic [27:0] center_u;
    logic [27:0] center_v;
    logic [31:0] inv_focal_u;
    logic [31:0] inv_focal_v;
    logic [39:0] focal_baseline;
    logic [39:0] disparity_max;
    logic        uvd_mode;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              eol;
    logic [PROD_W-1:0] prod;
    logic [DMAG_W-1:0] du;
    logic              uneg;
    logic [DMAG_W-1:0] dv;
    logic              vneg;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    item_t head;
  } q_rd_t;

  function automatic logic [OUT_W-1:0] sat_encode(input logic neg,
                                                  input logic [QUO_W-1:0] mag);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] m;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    m   = (mag > lim) ? lim : mag;
    return neg ? OUT_W'(-m) : OUT_W'(m);
  endfunction

endpackage

`default_nettype wire

[hdl/dpb_front.sv]
// ----------------------------------------------------------------------------
// dpb_front
// Pixel counters, depth product and principal point offsets per item.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_front import dpb_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire cfg_t        cfg,
  input  wire logic        q_full,
  output q_wr_t            q_wr
);

  logic [COORD_BITS-1:0] col_r, row_r, u, v;
  logic [DMAG_W-1:0]     uq, vq, cu, cv;
  logic                  accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign u         = in_tuser ? '0 : col_r;
  assign v         = in_tuser ? '0 : row_r;
  assign uq        = DMAG_W'(u) << FRAC_BITS;
  assign vq        = DMAG_W'(v) << FRAC_BITS;
  assign cu        = DMAG_W'(cfg.center_u);
  assign cv        = DMAG_W'(cfg.center_v);

  always_comb begin
    q_wr.push       = accept;
    q_wr.item.valid = (in_tdata != 16'd0);
    q_wr.item.eol   = in_tlast;
    q_wr.item.prod  = PROD_W'(in_tdata) * PROD_W'(cfg.depth_gain);
    q_wr.item.uneg  = uq < cu;
    q_wr.item.vneg  = vq < cv;
    q_wr.item.du    = (uq < cu) ? cu - uq : uq - cu;
    q_wr.item.dv    = (vq < cv) ? cv - vq : vq - cv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        col_r <= '0;
        row_r <= v + 1'b1;
      end else begin
        col_r <= u + 1'b1;
        row_r <= v;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/dpb_queue.sv]
// ----------------------------------------------------------------------------
// dpb_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_queue import dpb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  input  wire logic  pop,
  output logic       full,
  output q_rd_t      q_rd
);

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign q_rd.empty = (cnt_r == 2'd0);
  assign q_rd.head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (q_wr.push) mem_r[wp_r] <= q_wr.item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (q_wr.push) wp_r <= !wp_r;
      if (pop)       rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(q_wr.push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

[hdl/dpb_back.sv]
// ----------------------------------------------------------------------------
// dpb_back
// Point arithmetic: shared 32x32 multiply-accumulate and radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_back import dpb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire q_rd_t q_rd,
  output logic       pop,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output logic [119:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_FIN, ST_DIV, ST_DIVFIN, ST_DONE
  } state_t;

  state_t            state_r;
  item_t             it_r;
  logic [2:0]        step_r;
  logic              phase_r;
  logic [5:0]        cnt_r;
  logic [63:0]       mprod_r;
  logic [T_W-1:0]    t_r;
  logic [ACC_W-1:0]  acc_r;
  logic [QUO_W-1:0]  quo_r;
  logic [PROD_W-1:0] rem_r;
  logic [OUT_W-1:0]  x_r, y_r, z_r;
  logic              valid_r, last_r;

  logic [31:0]       mul_a, mul_b, inv;
  logic [DMAG_W-1:0] dmag;
  logic              neg;
  logic [PROD_W:0]   rem_sh;
  logic              ge;
  logic [QUO_W-1:0]  dmax, fin_mag;

  assign pop        = (state_r == ST_IDLE) && !q_rd.empty;
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = {z_r, y_r, x_r};
  assign out_tuser  = valid_r;
  assign out_tlast  = last_r;

  assign inv    = phase_r ? cfg.inv_focal_v : cfg.inv_focal_u;
  assign dmag   = phase_r ? it_r.dv : it_r.du;
  assign neg    = phase_r ? it_r.vneg : it_r.uneg;
  assign rem_sh = {rem_r, quo_r[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, it_r.prod};
  assign dmax   = QUO_W'(cfg.disparity_max);
  assign fin_mag = (|acc_r[ACC_W-1:96]) ? '1 : QUO_W'(acc_r[95:56]);

  always_comb begin
    mul_b = inv;
    unique case (step_r)
      3'd0: mul_a = it_r.prod[31:0];
      3'd1: mul_a = 32'(it_r.prod[PROD_W-1:32]);
      3'd2: begin mul_a = t_r[31:0];  mul_b = dmag; end
      3'd3: begin mul_a = t_r[63:32]; mul_b = dmag; end
      3'd4: begin mul_a = 32'(t_r[T_W-1:64]); mul_b = dmag; end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_rd.empty) begin
            it_r    <= q_rd.head;
            last_r  <= q_rd.head.eol;
            valid_r <= q_rd.head.valid;
            step_r  <= '0;
            phase_r <= 1'b0;
            cnt_r   <= '0;
            if (!q_rd.head.valid) begin
              x_r <= '0; y_r <= '0; z_r <= '0;
              state_r <= ST_DONE;
            end else if (cfg.uvd_mode) begin
              x_r <= sat_encode(q_rd.head.uneg, QUO_W'(q_rd.head.du));
              y_r <= sat_encode(q_rd.head.vneg, QUO_W'(q_rd.head.dv));
              quo_r <= {cfg.focal_baseline, 24'd0};
              rem_r <= '0;
              if (q_rd.head.prod == '0) begin
                z_r     <= sat_encode(1'b1, NEG_LIMIT);
                state_r <= ST_DONE;
              end else begin
                state_r <= ST_DIV;
              end
            end else begin
              z_r <= sat_encode(1'b0,
                       QUO_W'(q_rd.head.prod >> (GAIN_FRAC - FRAC_BITS)));
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          mprod_r <= 64'(mul_a) * 64'(mul_b);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          unique case (step_r)
            3'd0: t_r   <= T_W'(mprod_r);
            3'd1: t_r   <= t_r + (T_W'(mprod_r) << 32);
            3'd2: acc_r <= ACC_W'(mprod_r);
            3'd3: acc_r <= acc_r + (ACC_W'(mprod_r) << 32);
            default: acc_r <= acc_r + (ACC_W'(mprod_r) << 64);
          endcase
          if (step_r == 3'd4) begin
            state_r <= ST_FIN;
          end else begin
            step_r  <= step_r + 3'd1;
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          step_r <= '0;
          if (!phase_r) begin
            x_r     <= sat_encode(neg, fin_mag);
            phase_r <= 1'b1;
            state_r <= ST_MUL;
          end else begin
            y_r     <= sat_encode(neg, fin_mag);
            state_r <= ST_DONE;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? PROD_W'(rem_sh - {1'b0, it_r.prod}) : rem_sh[PROD_W-1:0];
          quo_r <= {quo_r[QUO_W-2:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= ST_DIVFIN;
        end
        ST_DIVFIN: begin
          if (quo_r > dmax) z_r <= sat_encode(1'b1, quo_r - dmax);
          else              z_r <= sat_encode(1'b0, dmax - quo_r);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_tready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/depth_pixel_backprojection.sv]
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Raw depth raster to 3-D points, metric XYZ or pixel offsets plus disparity.
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser          | tlast
// in_     | in  | depth_raw[15:0]                | start_of_frame | end_of_line
// out_    | out | point_x, point_y, point_z [119:0] | point_valid  | row_end
// cfg_    | in  | cfg_wdata[39:0] at cfg_addr    | -              | -
//
// Metric point: from queue to output in 10 multiply-accumulate steps on one
// 32x32 multiplier. Disparity point: 64-step divider.
// Invalid pixel or zero gain in disparity mode: no arithmetic steps.
// A two-item queue lets the input run on while the back end works or stalls.
// Reset is synchronous; no clearing pass.
`default_nettype none

module depth_pixel_backprojection import dpb_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // depth_raw
  input  wire logic         in_tuser,   // start_of_frame
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [119:0]      out_tdata,  // point_x, point_y, point_z
  output logic              out_tuser,  // point_valid
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [39:0]  cfg_wdata
);

  cfg_t  cfg_r;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_gain     <= 32'd16777;
      cfg_r.center_u       <= 28'd20877046;
      cfg_r.center_v       <= 28'd16786600;
      cfg_r.inv_focal_u    <= 32'd7345566;
      cfg_r.inv_focal_v    <= 32'd7333012;
      cfg_r.focal_baseline <= 40'd38319030;
      cfg_r.disparity_max  <= 40'd54741500;
      cfg_r.uvd_mode       <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_DEPTH_GAIN:     cfg_r.depth_gain     <= cfg_wdata[31:0];
        REG_CENTER_U:       cfg_r.center_u       <= cfg_wdata[27:0];
        REG_CENTER_V:       cfg_r.center_v       <= cfg_wdata[27:0];
        REG_INV_FOCAL_U:    cfg_r.inv_focal_u    <= cfg_wdata[31:0];
        REG_INV_FOCAL_V:    cfg_r.inv_focal_v    <= cfg_wdata[31:0];
        REG_FOCAL_BASELINE: cfg_r.focal_baseline <= cfg_wdata;
        REG_DISPARITY_MAX:  cfg_r.disparity_max  <= cfg_wdata;
        REG_UVD_MODE:       cfg_r.uvd_mode       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dpb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .cfg(cfg_r), .q_full, .q_wr
  );

  dpb_queue u_queue (
    .clk, .rst_n, .q_wr, .pop(q_pop), .full(q_full), .q_rd
  );

  dpb_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_rd, .pop(q_pop),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

`default_nettype wire

[hdl/dpb_checker.sv]
// ----------------------------------------------------------------------------
// dpb_port_checks
// Port-level checks on the result channel of the back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_port_checks (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [119:0] out_tdata,
  input wire logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 120'd0)
    else $error("invalid point carries non-zero coordinates");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

endmodule

bind depth_pixel_backprojection dpb_port_checks u_dpb_port_checks (.*);

`default_nettype wire

[verif/dpb_checker.sv]
// ----------------------------------------------------------------------------
// dpb_checker
// Watches the pixel, point and register ports of the depth back-projection
// block, predicts one point per accepted pixel and compares each point.
// ----------------------------------------------------------------------------
`default_nettype none

module dpb_checker import dpb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [15:0]  in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [119:0] out_tdata,
  input  wire logic         out_tuser,
  input  wire logic         out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [39:0]  cfg_wdata,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [39:0] x;
    logic [39:0] y;
    logic [39:0] z;
    logic        valid;
    logic        row_end;
  } point_t;

  point_t      point_queue[$];
  cfg_t        shadow;
  logic [11:0] col_cnt;
  logic [11:0] row_cnt;

  function automatic logic [39:0] clamp_signed(input logic neg, input logic [71:0] mag);
    logic [71:0] lim;
    logic [71:0] m;
    lim = neg ? 72'(NEG_LIMIT) : 72'(POS_LIMIT);
    m   = (mag > lim) ? lim : mag;
    return neg ? 40'(-m) : 40'(m);
  endfunction

  function automatic logic [39:0] scale_coord(input logic neg, input logic [31:0] dmag,
                                              input logic [47:0] p, input logic [31:0] invf);
    logic [127:0] t;
    t = 128'(dmag) * 128'(p) * 128'(invf);
    return clamp_signed(neg, 72'(t >> 56));
  endfunction

  function automatic point_t project(input logic [15:0] raw, input logic [11:0] u,
                                     input logic [11:0] v, input logic eol);
    point_t      pt;
    logic [31:0] uq, vq, du, dv;
    logic        un, vn;
    logic [47:0] p;
    logic [63:0] q;
    pt = '{x: '0, y: '0, z: '0, valid: 1'b0, row_end: eol};
    if (raw != 0) begin
      uq = 32'(u) << FRAC_BITS;
      vq = 32'(v) << FRAC_BITS;
      un = uq < 32'(shadow.center_u);
      vn = vq < 32'(shadow.center_v);
      du = un ? 32'(shadow.center_u) - uq : uq - 32'(shadow.center_u);
      dv = vn ? 32'(shadow.center_v) - vq : vq - 32'(shadow.center_v);
      p  = 48'(raw) * 48'(shadow.depth_gain);
      pt.valid = 1'b1;
      if (shadow.uvd_mode) begin
        pt.x = clamp_signed(un, 72'(du));
        pt.y = clamp_signed(vn, 72'(dv));
        if (p == 0) begin
          pt.z = clamp_signed(1'b1, 72'(NEG_LIMIT));
        end else begin
          q = (64'(shadow.focal_baseline) << 24) / 64'(p);
          if (q > 64'(shadow.disparity_max))
            pt.z = clamp_signed(1'b1, 72'(q - 64'(shadow.disparity_max)));
          else
            pt.z = clamp_signed(1'b0, 72'(64'(shadow.disparity_max) - q));
        end
      end else begin
        pt.z = clamp_signed(1'b0, 72'(p >> (GAIN_FRAC - FRAC_BITS)));
        pt.x = scale_coord(un, du, p, shadow.inv_focal_u);
        pt.y = scale_coord(vn, dv, p, shadow.inv_focal_v);
      end
    end
    return pt;
  endfunction

  assign pending = point_queue.size();

  initial errors = 0;

  always @(posedge clk) begin
    point_t      exp_pt;
    logic [11:0] u, v;
    if (!rst_n) begin
      shadow <= '{depth_gain: 32'd16777, center_u: 28'd20877046, center_v: 28'd16786600,
                  inv_focal_u: 32'd7345566, inv_focal_v: 32'd7333012,
                  focal_baseline: 40'd38319030, disparity_max: 40'd54741500,
                  uvd_mode: 1'b0};
      col_cnt <= '0;
      row_cnt <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_DEPTH_GAIN:     shadow.depth_gain     <= cfg_wdata[31:0];
          REG_CENTER_U:       shadow.center_u       <= cfg_wdata[27:0];
          REG_CENTER_V:       shadow.center_v       <= cfg_wdata[27:0];
          REG_INV_FOCAL_U:    shadow.inv_focal_u    <= cfg_wdata[31:0];
          REG_INV_FOCAL_V:    shadow.inv_focal_v    <= cfg_wdata[31:0];
          REG_FOCAL_BASELINE: shadow.focal_baseline <= cfg_wdata;
          REG_DISPARITY_MAX:  shadow.disparity_max  <= cfg_wdata;
          REG_UVD_MODE:       shadow.uvd_mode       <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        u = in_tuser ? 12'd0 : col_cnt;
        v = in_tuser ? 12'd0 : row_cnt;
        point_queue.push_back(project(in_tdata, u, v, in_tlast));
        col_cnt <= in_tlast ? 12'd0 : u + 12'd1;
        row_cnt <= in_tlast ? v + 12'd1 : v;
      end
      if (out_tvalid && out_tready) begin
        if (point_queue.size() == 0) begin
          $display("%0t: unexpected point, actual %h valid %b last %b",
                   $time, out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          exp_pt = point_queue.pop_front();
          if (out_tdata[39:0] !== exp_pt.x) begin
            $display("%0t: point_x expected %h actual %h", $time, exp_pt.x, out_tdata[39:0]);
            errors++;
          end
          if (out_tdata[79:40] !== exp_pt.y) begin
            $display("%0t: point_y expected %h actual %h", $time, exp_pt.y, out_tdata[79:40]);
            errors++;
          end
          if (out_tdata[119:80] !== exp_pt.z) begin
            $display("%0t: point_z expected %h actual %h", $time, exp_pt.z,
                     out_tdata[119:80]);
            errors++;
          end
          if (out_tuser !== exp_pt.valid) begin
            $display("%0t: point_valid expected %b actual %b", $time, exp_pt.valid, out_tuser);
            errors++;
          end
          if (out_tlast !== exp_pt.row_end) begin
            $display("%0t: row_end expected %b actual %b", $time, exp_pt.row_end, out_tlast);
            errors++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[verif/tb_depth_pixel_backprojection.sv]
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection
// Drives raster frames, noise pixels and register settings into the depth
// back-projection block with random gaps and stalls; the checker predicts
// and compares every point.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_depth_pixel_backprojection import dpb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [39:0]  cfg_wdata;
  int           errors;
  int           pending;
  int           idle_cycles;
  int           points_seen;
  bit           no_gaps;

  depth_pixel_backprojection dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  dpb_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_addr, .cfg_wdata, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_depth_pixel_backprojection: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    out_tready  = 1'b0;
    points_seen = 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (points_seen == 150) begin
        stall = 600;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      points_seen++;
    end
  end

  task automatic send_pixel(input logic [15:0] raw, input logic sof, input logic eol);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tuser  <= sof;
    in_tlast  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [39:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] gain, input logic [27:0] cu, input logic [27:0] cv,
                         input logic [31:0] fu, input logic [31:0] fv,
                         input logic [39:0] fb, input logic [39:0] dm, input logic mode);
    drain();
    write_reg(REG_DEPTH_GAIN, 40'(gain));
    write_reg(REG_CENTER_U, 40'(cu));
    write_reg(REG_CENTER_V, 40'(cv));
    write_reg(REG_INV_FOCAL_U, 40'(fu));
    write_reg(REG_INV_FOCAL_V, 40'(fv));
    write_reg(REG_FOCAL_BASELINE, fb);
    write_reg(REG_DISPARITY_MAX, dm);
    write_reg(REG_UVD_MODE, 40'(mode));
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [39:0] pick_word(input int bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 40'((64'd1 << bits) - 64'd1);
      default: return 40'(r & ((64'd1 << bits) - 64'd1));
    endcase
  endfunction

  task automatic random_config();
    set_all(32'(pick_word(32)) >> $urandom_range(0, 16), 28'(pick_word(28)),
            28'(pick_word(28)) >> $urandom_range(0, 8), 32'(pick_word(32)),
            32'(pick_word(32)), pick_word(40) >> $urandom_range(0, 14),
            pick_word(40) >> $urandom_range(0, 14), 1'($urandom));
  endtask

  task automatic send_frame(input int cols, input int rows);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        send_pixel(pick_raw(), r == 0 && c == 0, c == cols - 1);
      end
    end
  endtask

  initial begin
    int sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    no_gaps   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(16'd1000, 1'b1, 1'b0);
    send_pixel(16'd0, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    send_pixel(16'd1, 1'b0, 1'b0);
    send_pixel(16'd500, 1'b1, 1'b1);
    send_pixel(16'd500, 1'b0, 1'b0);

    set_all(32'd0, 28'd20877046, 28'd16786600, 32'd7345566, 32'd7333012,
            40'd38319030, 40'd54741500, 1'b0);
    send_pixel(16'd777, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1);
    drain();
    write_reg(REG_UVD_MODE, 40'd1);
    send_pixel(16'd777, 1'b0, 1'b0);
    send_pixel(16'd0, 1'b0, 1'b1);

    set_all(32'hFFFF_FFFF, 28'd0, 28'hFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'd1, 1'b0, 1'b1);
    send_pixel(16'h8000, 1'b0, 1'b0);
    drain();
    write_reg(REG_UVD_MODE, 40'd1);
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'd1, 1'b0, 1'b1);
    drain();
    write_reg(REG_DISPARITY_MAX, 40'd0);
    send_pixel(16'd3, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b1);
    drain();
    write_reg(REG_FOCAL_BASELINE, 40'd0);
    send_pixel(16'd9, 1'b0, 1'b0);

    set_all(32'd16777, 28'hFFF_FFFF, 28'd0, 32'd7345566, 32'd7333012,
            40'd38319030, 40'd54741500, 1'b1);
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_pixel((i < 3 || i > 8) ? 16'd200 : 16'd0, i == 0, i == 5 || i == 11);
    end
    no_gaps = 1'b0;

    set_all(32'd16777, 28'd20877046, 28'd16786600, 32'd7345566, 32'd7333012,
            40'd38319030, 40'd54741500, 1'b0);
    sent = 0;
    while (sent < 920) begin
      if (sent % 150 == 149) begin
        random_config();
      end
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(pick_raw(), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        automatic int cols = $urandom_range(1, 6);
        automatic int rows = $urandom_range(1, 4);
        send_frame(cols, rows);
        sent += cols * rows;
      end
      if ($urandom_range(0, 3) == 0) begin
        no_gaps = ~no_gaps;
      end
    end
    no_gaps = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("tb_depth_pixel_backprojection: done, clean");
    end else begin
      $display("tb_depth_pixel_backprojection: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
